/* rtl/park_drive_interlock_macros.svh */
// Assertion macros for the park/drive interlock.
`ifndef PARK_DRIVE_INTERLOCK_MACROS_SVH
`define PARK_DRIVE_INTERLOCK_MACROS_SVH

`ifndef SYNTH
`define PDI_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PDI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PDI_ASSERT(label, clk, rst, prop, msg)
`define PDI_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* rtl/pdi_pkg.sv */
// Types, constants and register indexes for the park/drive interlock.
package pdi_pkg;

  localparam int TIME_BITS   = 20;
  localparam int SAMPLE_BITS = 12;
  localparam int TICK_BITS   = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = TIME_BITS;

  typedef logic [TIME_BITS-1:0]   time_t;
  typedef logic [TIME_BITS:0]     time_sum_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;

  localparam time_t TIME_MAX = {TIME_BITS{1'b1}};

  localparam logic [CFG_IDX_BITS-1:0] REG_BRAKE_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BUZZER_DURATION   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE_DURATION = 2'd2;

  localparam sample_t RST_BRAKE_THRESHOLD   = sample_t'(200);
  localparam time_t   RST_BUZZER_DURATION   = time_t'(2000);
  localparam time_t   RST_DEBOUNCE_DURATION = time_t'(50);

  typedef struct packed {
    logic                 raw_drive_switch;
    logic                 inverter_ready;
    sample_t              brake_pressure;
    sample_t              accel_position;
    logic [TICK_BITS-1:0] elapsed_ticks;
  } in_t;

  typedef struct packed {
    logic drive_mode;
    logic buzzer_on;
  } out_t;

  typedef struct packed {
    sample_t brake_threshold;
    time_t   buzzer_duration;
    time_t   debounce_duration;
  } cfg_t;

  typedef struct packed {
    logic  in_drive;
    logic  debounced_switch;
    time_t debounce_elapsed;
    time_t buzzer_elapsed;
  } state_t;

endpackage

/* rtl/park_drive_interlock.sv */
// Park/drive interlock top level: request register, state update, result register.
// An accepted request waits in the request register until the state update moves its result into the result register.
// Throughput: one request per cycle while results are taken; the combinational state update loop sets this.
// A new request is taken while a finished result waits, until both registers are full.
// Reset (rst, synchronous, high): park, timers cleared, config registers at defaults.
`include "park_drive_interlock_macros.svh"

module park_drive_interlock (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pdi_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pdi_pkg::out_t                       out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pdi_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [pdi_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  pdi_pkg::cfg_t   cfg;
  pdi_pkg::state_t st;
  pdi_pkg::state_t st_next;
  pdi_pkg::in_t    req_q;
  pdi_pkg::out_t   rsp_next;
  logic            req_valid;
  logic            advance;

  assign cfg_ready = 1'b1;
  assign advance   = req_valid && (!out_valid || out_ready);
  assign in_ready  = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brake_threshold   <= pdi_pkg::RST_BRAKE_THRESHOLD;
      cfg.buzzer_duration   <= pdi_pkg::RST_BUZZER_DURATION;
      cfg.debounce_duration <= pdi_pkg::RST_DEBOUNCE_DURATION;
    end else if (cfg_valid) begin
      case (cfg_index)
        pdi_pkg::REG_BRAKE_THRESHOLD:
          cfg.brake_threshold <= cfg_data[pdi_pkg::SAMPLE_BITS-1:0];
        pdi_pkg::REG_BUZZER_DURATION:
          cfg.buzzer_duration <= cfg_data[pdi_pkg::TIME_BITS-1:0];
        pdi_pkg::REG_DEBOUNCE_DURATION:
          cfg.debounce_duration <= cfg_data[pdi_pkg::TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  pdi_step u_step (
    .st      (st),
    .req     (req_q),
    .cfg     (cfg),
    .st_next (st_next),
    .rsp     (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (in_valid && in_ready) begin
        req_valid <= 1'b1;
      end else if (advance) begin
        req_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        st        <= st_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_q <= in_data;
    end
    if (advance) begin
      out_data <= rsp_next;
    end
  end

  `PDI_ASSERT(a_buzzer_in_drive, clk, rst, out_valid |-> (!out_data.buzzer_on || out_data.drive_mode), "buzzer on while parked")
  `PDI_ASSERT(a_mode_matches_state, clk, rst, out_valid |-> (out_data.drive_mode == st.in_drive), "result mode differs from state")
  `PDI_ASSERT(a_enter_clears_timer, clk, rst, $rose(st.in_drive) |-> (st.buzzer_elapsed == '0), "buzzer timer not cleared on entering drive")
  `PDI_ASSERT(a_ready_when_empty, clk, rst, !req_valid |-> in_ready, "request register empty but not ready")

endmodule

/* rtl/pdi_step.sv */
// One request's state update and result: debounce, interlock and buzzer timer.
module pdi_step (
  input  pdi_pkg::state_t st,
  input  pdi_pkg::in_t    req,
  input  pdi_pkg::cfg_t   cfg,
  output pdi_pkg::state_t st_next,
  output pdi_pkg::out_t   rsp
);

  pdi_pkg::time_sum_t deb_sum;
  pdi_pkg::time_sum_t buz_sum;
  pdi_pkg::time_t     deb_acc;
  pdi_pkg::time_t     buz_acc;
  logic               rising;
  logic               can_enter;

  assign deb_sum = pdi_pkg::time_sum_t'(st.debounce_elapsed)
                 + pdi_pkg::time_sum_t'(req.elapsed_ticks);
  assign buz_sum = pdi_pkg::time_sum_t'(st.buzzer_elapsed)
                 + pdi_pkg::time_sum_t'(req.elapsed_ticks);
  // saturate: carry out means past the top
  assign deb_acc = deb_sum[pdi_pkg::TIME_BITS] ? pdi_pkg::TIME_MAX
                                               : deb_sum[pdi_pkg::TIME_BITS-1:0];
  assign buz_acc = buz_sum[pdi_pkg::TIME_BITS] ? pdi_pkg::TIME_MAX
                                               : buz_sum[pdi_pkg::TIME_BITS-1:0];

  assign can_enter = req.inverter_ready
                   && (req.brake_pressure > cfg.brake_threshold)
                   && (req.accel_position == '0);

  always_comb begin
    st_next = st;
    if (req.raw_drive_switch == st.debounced_switch) begin
      st_next.debounce_elapsed = '0;
    end else if (deb_acc >= cfg.debounce_duration) begin
      st_next.debounced_switch = req.raw_drive_switch;
      st_next.debounce_elapsed = '0;
    end else begin
      st_next.debounce_elapsed = deb_acc;
    end

    rising = st_next.debounced_switch && !st.debounced_switch;

    if (st.in_drive) begin
      st_next.buzzer_elapsed = buz_acc;
      if (!st_next.debounced_switch || !req.inverter_ready) begin
        st_next.in_drive = 1'b0;
      end
    end else if (rising && can_enter) begin
      st_next.in_drive       = 1'b1;
      st_next.buzzer_elapsed = '0;
    end

    rsp.drive_mode = st_next.in_drive;
    rsp.buzzer_on  = st_next.in_drive && (st_next.buzzer_elapsed < cfg.buzzer_duration);
  end

endmodule
